FILE: hdl/pcm_pkg.sv
`default_nettype none
package pcm_pkg;

   localparam int MaxPoints = 256;
   localparam int CountW    = $clog2(MaxPoints);
   localparam int EdgeW     = 21;
   localparam int SumW      = 29;
   localparam int CentW     = 20;
   localparam int MomW      = 38;
   localparam int SqrtSteps = 21;
   localparam int DivSteps  = 67;
   localparam int ReqDataW  = 32;
   localparam int RspDataW  = 208;
   localparam int RspUserW  = 2;

   // divider operand selects, also the order of the final pass
   localparam logic [2:0] SelCx = 3'd0;
   localparam logic [2:0] SelCy = 3'd1;
   localparam logic [2:0] SelXx = 3'd2;
   localparam logic [2:0] SelYy = 3'd3;
   localparam logic [2:0] SelXy = 3'd4;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DXX,
      OP_DYY,
      OP_SQ_INIT,
      OP_SQ_STEP,
      OP_XAXA,
      OP_XBXB,
      OP_XAXB,
      OP_LXX,
      OP_YAYA,
      OP_YBYB,
      OP_YAYB,
      OP_LYY,
      OP_XAYA,
      OP_XBYB,
      OP_XAYB,
      OP_XBYA,
      OP_LXY,
      OP_LX,
      OP_LY,
      OP_COMMIT,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_STORE,
      OP_OUT
   } pcm_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DXX,
      ST_DYY,
      ST_SQ_INIT,
      ST_SQ,
      ST_XAXA,
      ST_XBXB,
      ST_XAXB,
      ST_LXX,
      ST_YAYA,
      ST_YBYB,
      ST_YAYB,
      ST_LYY,
      ST_XAYA,
      ST_XBYB,
      ST_XAYB,
      ST_XBYA,
      ST_LXY,
      ST_LX,
      ST_LY,
      ST_COMMIT,
      ST_DIV_INIT,
      ST_DIV,
      ST_DIV_STORE,
      ST_OUT
   } pcm_state_type;

   typedef struct packed {
      pcm_op_type op;
      logic [2:0] sel;
   } pcm_cmd_type;

   typedef struct packed {
      logic have_prev;
      logic fin;
      logic sum_zero;
      logic sqrt_last;
      logic div_last;
      logic out_free;
   } pcm_stat_type;

endpackage
`default_nettype wire

FILE: hdl/pcm_ctrl.sv
`default_nettype none
module pcm_ctrl
   import pcm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire pcm_stat_type stat,
   output      pcm_cmd_type  cmd
);

   pcm_state_type state_ff, state_in;
   logic [2:0]    sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SelCx;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.sel    = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = stat.have_prev ? ST_DXX : ST_COMMIT;
            end
         end
         ST_DXX:     begin cmd.op = OP_DXX;     state_in = ST_DYY;     end
         ST_DYY:     begin cmd.op = OP_DYY;     state_in = ST_SQ_INIT; end
         ST_SQ_INIT: begin cmd.op = OP_SQ_INIT; state_in = ST_SQ;      end
         ST_SQ: begin
            cmd.op = OP_SQ_STEP;
            if (stat.sqrt_last) state_in = ST_XAXA;
         end
         ST_XAXA: begin cmd.op = OP_XAXA; state_in = ST_XBXB; end
         ST_XBXB: begin cmd.op = OP_XBXB; state_in = ST_XAXB; end
         ST_XAXB: begin cmd.op = OP_XAXB; state_in = ST_LXX;  end
         ST_LXX:  begin cmd.op = OP_LXX;  state_in = ST_YAYA; end
         ST_YAYA: begin cmd.op = OP_YAYA; state_in = ST_YBYB; end
         ST_YBYB: begin cmd.op = OP_YBYB; state_in = ST_YAYB; end
         ST_YAYB: begin cmd.op = OP_YAYB; state_in = ST_LYY;  end
         ST_LYY:  begin cmd.op = OP_LYY;  state_in = ST_XAYA; end
         ST_XAYA: begin cmd.op = OP_XAYA; state_in = ST_XBYB; end
         ST_XBYB: begin cmd.op = OP_XBYB; state_in = ST_XAYB; end
         ST_XAYB: begin cmd.op = OP_XAYB; state_in = ST_XBYA; end
         ST_XBYA: begin cmd.op = OP_XBYA; state_in = ST_LXY;  end
         ST_LXY:  begin cmd.op = OP_LXY;  state_in = ST_LX;   end
         ST_LX:   begin cmd.op = OP_LX;   state_in = ST_LY;   end
         ST_LY:   begin cmd.op = OP_LY;   state_in = ST_COMMIT; end
         ST_COMMIT: begin
            cmd.op = OP_COMMIT;
            sel_in = SelCx;
            if (stat.fin && !stat.sum_zero) state_in = ST_DIV_INIT;
            else state_in = ST_OUT;
         end
         ST_DIV_INIT: begin cmd.op = OP_DIV_INIT; state_in = ST_DIV; end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (stat.div_last) state_in = ST_DIV_STORE;
         end
         ST_DIV_STORE: begin
            cmd.op = OP_DIV_STORE;
            if (sel_ff == SelXy) begin
               state_in = ST_OUT;
            end else begin
               sel_in   = sel_ff + 3'd1;
               state_in = ST_DIV_INIT;
            end
         end
         ST_OUT: begin
            cmd.op = OP_OUT;
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && !stat.div_last |=> state_ff == ST_DIV)
      else $error("divider left early");
   a_sqrt_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQ && !stat.sqrt_last |=> state_ff == ST_SQ)
      else $error("root left early");
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && !stat.out_free |=> state_ff == ST_OUT)
      else $error("result dropped");

endmodule
`default_nettype wire

FILE: hdl/pcm_dpath.sv
`default_nettype none
module pcm_dpath
   import pcm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pcm_cmd_type         cmd,
   output      pcm_stat_type        stat,
   input  wire logic [ReqDataW-1:0] req_tdata,
   input  wire logic                req_tlast,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [RspDataW-1:0] rsp_tdata,
   output      logic [RspUserW-1:0] rsp_tuser
);

   logic signed [15:0] x_ff, y_ff, px_ff, py_ff;
   logic               last_ff, have_prev_ff;
   logic [CountW-1:0]  cnt_ff;
   logic [SumW-1:0]    len_sum_ff;
   logic signed [46:0] wx_ff, wy_ff;
   logic signed [61:0] wxx_ff, wyy_ff;
   logic signed [62:0] wxy_ff;
   logic signed [34:0] t_ff;
   logic [EdgeW-1:0]   edge_ff;
   logic [41:0]        sq_v_ff;
   logic [22:0]        sq_rem_ff;
   logic [4:0]         sq_cnt_ff;
   logic [66:0]        dvd_ff;
   logic [31:0]        den_ff, drem_ff;
   logic [MomW-1:0]    q_ff;
   logic               neg_ff;
   logic [6:0]         div_cnt_ff;
   logic signed [CentW-1:0] cx_ff, cy_ff;
   logic [MomW-1:0]    vx_ff, vy_ff, cxy_ff;
   logic               valid_ff;
   logic [RspDataW-1:0] data_ff;
   logic [RspUserW-1:0] user_ff;

   logic signed [16:0] dx, dy, xsum, ysum;
   logic signed [34:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [56:0] mul_p;
   logic [24:0]        sq_remw, sq_trial;
   logic [32:0]        d_remw;
   logic signed [62:0] dnum;
   logic [62:0]        dabs;
   logic [31:0]        s2, s3;
   logic [MomW-1:0]    qs;
   logic [39:0]        pp_abs, pp_tq, pp_tr;
   logic               fin, out_fire, sum_zero;
   logic [RspDataW-1:0] data_in;

   assign dx   = 17'(x_ff) - 17'(px_ff);
   assign dy   = 17'(y_ff) - 17'(py_ff);
   assign xsum = 17'(x_ff) + 17'(px_ff);
   assign ysum = 17'(y_ff) + 17'(py_ff);
   assign mul_p = mul_a * mul_b;
   assign fin = last_ff;
   assign sum_zero = (len_sum_ff == '0);
   assign out_fire = (cmd.op == OP_OUT) && (!valid_ff || rsp_tready);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_DXX:  begin mul_a = 35'(dx);    mul_b = 22'(dx);    end
         OP_DYY:  begin mul_a = 35'(dy);    mul_b = 22'(dy);    end
         OP_XAXA: begin mul_a = 35'(px_ff); mul_b = 22'(px_ff); end
         OP_XBXB: begin mul_a = 35'(x_ff);  mul_b = 22'(x_ff);  end
         OP_XAXB: begin mul_a = 35'(px_ff); mul_b = 22'(x_ff);  end
         OP_YAYA: begin mul_a = 35'(py_ff); mul_b = 22'(py_ff); end
         OP_YBYB: begin mul_a = 35'(y_ff);  mul_b = 22'(y_ff);  end
         OP_YAYB: begin mul_a = 35'(py_ff); mul_b = 22'(y_ff);  end
         OP_XAYA: begin mul_a = 35'(px_ff); mul_b = 22'(py_ff); end
         OP_XBYB: begin mul_a = 35'(x_ff);  mul_b = 22'(y_ff);  end
         OP_XAYB: begin mul_a = 35'(px_ff); mul_b = 22'(y_ff);  end
         OP_XBYA: begin mul_a = 35'(x_ff);  mul_b = 22'(py_ff); end
         OP_LXX, OP_LYY, OP_LXY: begin
            mul_a = t_ff;
            mul_b = {1'b0, edge_ff};
         end
         OP_LX: begin mul_a = 35'(xsum); mul_b = {1'b0, edge_ff}; end
         OP_LY: begin mul_a = 35'(ysum); mul_b = {1'b0, edge_ff}; end
         OP_DIV_STORE: begin
            case (cmd.sel)
               SelXx:   begin mul_a = 35'(cx_ff); mul_b = 22'(cx_ff); end
               SelYy:   begin mul_a = 35'(cy_ff); mul_b = 22'(cy_ff); end
               SelXy:   begin mul_a = 35'(cx_ff); mul_b = 22'(cy_ff); end
               default: begin mul_a = '0;         mul_b = '0;         end
            endcase
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // root digit, divider bit, final correction terms
   always_comb begin
      sq_remw  = {sq_rem_ff, sq_v_ff[41:40]};
      sq_trial = {2'b00, edge_ff, 2'b01};
      d_remw   = {drem_ff, dvd_ff[66]};
      case (cmd.sel)
         SelCx:   dnum = 63'(wx_ff);
         SelCy:   dnum = 63'(wy_ff);
         SelXx:   dnum = 63'(wxx_ff);
         SelYy:   dnum = 63'(wyy_ff);
         default: dnum = wxy_ff;
      endcase
      dabs   = dnum[62] ? 63'(-dnum) : dnum;
      s2     = {2'b00, len_sum_ff, 1'b0};
      s3     = s2 + {3'b000, len_sum_ff};
      qs     = neg_ff ? MomW'(-q_ff) : q_ff;
      pp_abs = mul_p[39] ? 40'(-mul_p[39:0]) : mul_p[39:0];
      pp_tq  = pp_abs >> 4;
      pp_tr  = mul_p[39] ? 40'(-pp_tq) : pp_tq;
      if (fin) begin
         data_in = {4'b0, cxy_ff, vy_ff, vx_ff, cy_ff, cx_ff, len_sum_ff, edge_ff};
         if (sum_zero) data_in = {{(RspDataW-EdgeW){1'b0}}, edge_ff};
      end else begin
         data_in = {{(RspDataW-EdgeW){1'b0}}, edge_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         cnt_ff       <= '0;
         len_sum_ff   <= '0;
         wx_ff        <= '0;
         wy_ff        <= '0;
         wxx_ff       <= '0;
         wyy_ff       <= '0;
         wxy_ff       <= '0;
         px_ff        <= '0;
         py_ff        <= '0;
         valid_ff     <= 1'b0;
         last_ff      <= 1'b0;
         sq_cnt_ff    <= '0;
         div_cnt_ff   <= '0;
      end else begin
         if (out_fire) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
         case (cmd.op)
            OP_LOAD: begin
               x_ff    <= req_tdata[15:0];
               y_ff    <= req_tdata[31:16];
               last_ff <= req_tlast || (cnt_ff == CountW'(MaxPoints - 1));
               edge_ff <= '0;
            end
            OP_DXX, OP_XAXA, OP_YAYA, OP_XAYA: t_ff <= mul_p[34:0];
            OP_DYY, OP_XBXB, OP_XAXB, OP_YBYB, OP_YAYB, OP_XAYB, OP_XBYA:
               t_ff <= t_ff + mul_p[34:0];
            OP_XBYB: t_ff <= (t_ff + mul_p[34:0]) <<< 1;
            OP_SQ_INIT: begin
               sq_v_ff   <= {t_ff[33:0], 8'b0};
               sq_rem_ff <= '0;
               edge_ff   <= '0;
               sq_cnt_ff <= 5'(SqrtSteps - 1);
            end
            OP_SQ_STEP: begin
               sq_v_ff   <= sq_v_ff << 2;
               sq_cnt_ff <= sq_cnt_ff - 5'd1;
               if (sq_remw >= sq_trial) begin
                  sq_rem_ff <= 23'(sq_remw - sq_trial);
                  edge_ff   <= {edge_ff[EdgeW-2:0], 1'b1};
               end else begin
                  sq_rem_ff <= sq_remw[22:0];
                  edge_ff   <= {edge_ff[EdgeW-2:0], 1'b0};
               end
            end
            OP_LXX: wxx_ff <= wxx_ff + 62'(mul_p);
            OP_LYY: wyy_ff <= wyy_ff + 62'(mul_p);
            OP_LXY: wxy_ff <= wxy_ff + 63'(mul_p);
            OP_LX: begin
               wx_ff      <= wx_ff + mul_p[46:0];
               len_sum_ff <= len_sum_ff + SumW'(edge_ff);
            end
            OP_LY: wy_ff <= wy_ff + mul_p[46:0];
            OP_COMMIT: begin
               px_ff        <= x_ff;
               py_ff        <= y_ff;
               have_prev_ff <= 1'b1;
               cnt_ff       <= cnt_ff + 1'b1;
            end
            OP_DIV_INIT: begin
               neg_ff     <= dnum[62];
               dvd_ff     <= {dabs, 4'b0};
               drem_ff    <= '0;
               q_ff       <= '0;
               div_cnt_ff <= 7'(DivSteps - 1);
               case (cmd.sel)
                  SelCx, SelCy: den_ff <= s2;
                  SelXx, SelYy: den_ff <= s3;
                  default:      den_ff <= {s3[30:0], 1'b0};
               endcase
            end
            OP_DIV_STEP: begin
               dvd_ff     <= dvd_ff << 1;
               div_cnt_ff <= div_cnt_ff - 7'd1;
               if (d_remw >= {1'b0, den_ff}) begin
                  drem_ff <= 32'(d_remw - {1'b0, den_ff});
                  q_ff    <= {q_ff[MomW-2:0], 1'b1};
               end else begin
                  drem_ff <= d_remw[31:0];
                  q_ff    <= {q_ff[MomW-2:0], 1'b0};
               end
            end
            OP_DIV_STORE: begin
               case (cmd.sel)
                  SelCx:   cx_ff  <= qs[CentW-1:0];
                  SelCy:   cy_ff  <= qs[CentW-1:0];
                  SelXx:   vx_ff  <= qs - pp_tr[MomW-1:0];
                  SelYy:   vy_ff  <= qs - pp_tr[MomW-1:0];
                  default: cxy_ff <= qs - pp_tr[MomW-1:0];
               endcase
            end
            OP_OUT: begin
               if (out_fire) begin
                  data_ff  <= data_in;
                  user_ff  <= {fin && sum_zero, fin};
                  if (fin) begin
                     have_prev_ff <= 1'b0;
                     cnt_ff       <= '0;
                     len_sum_ff   <= '0;
                     wx_ff        <= '0;
                     wy_ff        <= '0;
                     wxx_ff       <= '0;
                     wyy_ff       <= '0;
                     wxy_ff       <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign stat.have_prev = have_prev_ff;
   assign stat.fin       = fin;
   assign stat.sum_zero  = sum_zero;
   assign stat.sqrt_last = (sq_cnt_ff == '0);
   assign stat.div_last  = (div_cnt_ff == '0);
   assign stat.out_free  = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

   a_fire_valid: assert property (@(posedge clock) disable iff (reset)
      out_fire |=> valid_ff)
      else $error("result word not presented");
   a_degen_final: assert property (@(posedge clock) disable iff (reset)
      valid_ff && user_ff[1] |-> user_ff[0])
      else $error("degenerate without final");
   a_contour_cleared: assert property (@(posedge clock) disable iff (reset)
      out_fire && fin |=> !have_prev_ff && len_sum_ff == '0)
      else $error("contour sums not cleared");

endmodule
`default_nettype wire

FILE: hdl/polyline_contour_moments.sv
// length-weighted centroid and second moments of an open polyline
// req channel: one word per vertex, tdata = {point_y, point_x}, tlast marks
// the final vertex. a vertex that makes 256 in one contour also ends it.
// rsp channel: one word per vertex. tdata holds the edge length (Q.4, zero
// for the first vertex) and, on the final vertex, total length, centroids and
// central moments; tuser[0] flags the final word, tuser[1] a zero-length
// contour (moments then zero).
// a vertex that opens a contour is only loaded, committed and output; any
// other adds two squares, a 21-step bit-pair square root and 15 steps on
// the one shared 35x22 multiplier. the final vertex adds five 67-step
// restoring divisions unless the total length is zero.
// one vertex is in work at a time; the result sits in an output register, so
// the next vertex is taken while the receiver stalls and holds only when a
// second result is ready before the first was taken.
// synchronous reset clears the contour sums and the previous vertex, no
// clearing pass.
`default_nettype none
module polyline_contour_moments
   import pcm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,  // point_x, point_y
   input  wire logic                req_tlast,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   // edge_length, total_length, centroid_x, centroid_y, variance_x,
   // variance_y, covariance_xy
   output      logic [RspDataW-1:0] rsp_tdata,
   output      logic [RspUserW-1:0] rsp_tuser   // final_res, degenerate
);

   pcm_cmd_type  cmd;
   pcm_stat_type stat;

   pcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pcm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
